// File: rtl/sinq_pkg.sv
package sinq_pkg;

  localparam int VAL_W = 12;
  localparam int ANS_W = 13;
  localparam int WIDX_MAX_W = 9;
  localparam int BIT_MAX_W = 6;
  localparam int CAND_W = 22;
  localparam int FLAG_CHUNK = 32;

  localparam int DEF_VALUE_RANGE = 4096;
  localparam int DEF_WORD_BITS = 64;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_QUERY,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [WIDX_MAX_W-1:0]  word;
    logic [BIT_MAX_W-1:0]   bit_idx;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_INSERT,
    ST_EXAM,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/sinq_ifs.sv
interface sinq_in_if import sinq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [VAL_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface sinq_out_if import sinq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ANS_W-1:0] answer;

  modport source (output valid, answer, input ready);
  modport sink (input valid, answer, output ready);
endinterface

// File: rtl/sinq_front.sv
module sinq_front import sinq_pkg::*; #(
  parameter int VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  sinq_in_if.sink    in_if,
  input  logic       clearing,
  input  logic       pop,
  output logic       q_valid,
  output entry_t     q_entry
);

  // word index by reciprocal multiply, exact for all 12-bit values
  localparam int SH = VAL_W + $clog2(WORD_BITS);
  localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int REC_W = VAL_W + 2;
  localparam int PROD_W = (SH + WIDX_MAX_W > VAL_W + REC_W) ? SH + WIDX_MAX_W : VAL_W + REC_W;

  logic [PROD_W-1:0]     prod;
  logic                  accept;

  logic                  st_v_r, st_v_nxt;
  logic                  st_act_r;
  logic [VAL_W-1:0]      st_val_r;
  logic [WIDX_MAX_W-1:0] st_q_r;

  logic [VAL_W-1:0]      base;
  logic [VAL_W-1:0]      rem;
  logic                  oor;
  logic                  drop;
  logic                  full;
  logic                  push;
  logic                  st_done;
  entry_t                ent;

  entry_t                fifo_r [2];
  logic                  wp_r, rp_r;
  logic [1:0]            cnt_r;

  assign prod = PROD_W'(in_if.value) * PROD_W'(RECIP);

  assign base = VAL_W'(32'(st_q_r) * WORD_BITS);
  assign rem = st_val_r - base;
  assign oor = 32'(st_val_r) >= VALUE_RANGE;
  assign drop = (st_act_r == ACT_INSERT) && oor;
  assign full = (cnt_r == 2'd2);
  assign st_done = st_v_r && (drop || !full);
  assign push = st_v_r && !drop && !full;

  assign in_if.ready = !clearing && (!st_v_r || st_done);
  assign accept = in_if.valid && in_if.ready;

  always_comb begin
    ent.word = st_q_r;
    ent.bit_idx = rem[BIT_MAX_W-1:0];
    if (st_act_r == ACT_INSERT) begin
      ent.kind = KIND_INSERT;
    end else if (oor) begin
      ent.kind = KIND_NONE;
    end else begin
      ent.kind = KIND_QUERY;
    end
  end

  always_comb begin
    st_v_nxt = st_v_r;
    if (accept) begin
      st_v_nxt = 1'b1;
    end else if (st_done) begin
      st_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else begin
      st_v_r <= st_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_act_r <= in_if.action;
      st_val_r <= in_if.value;
      st_q_r <= prod[SH +: WIDX_MAX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= ent;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_entry = fifo_r[rp_r];

endmodule

// File: rtl/sinq_back.sv
module sinq_back import sinq_pkg::*; #(
  parameter int VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  entry_t     q_entry,
  output logic       pop,
  output logic       clearing,
  sinq_out_if.source out_if
);

  localparam int LIM = (VALUE_RANGE < (1 << VAL_W)) ? VALUE_RANGE : (1 << VAL_W);
  localparam int STORE_WORDS = (LIM + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int CHUNKS = (STORE_WORDS + FLAG_CHUNK - 1) / FLAG_CHUNK;
  localparam int FLAG_PAD = CHUNKS * FLAG_CHUNK;
  localparam int FP_W = $clog2(FLAG_PAD);
  localparam int SCAN_W = $clog2(FLAG_PAD + 1);
  localparam int CH_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int OFF_W = $clog2(FLAG_CHUNK);

  function automatic logic [5:0] ffs(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      word_r, word_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [BIT_W-1:0]      pos_r, pos_nxt;
  logic                  none_r, none_nxt;
  logic                  ins_r, ins_nxt;
  logic [SCAN_W-1:0]     scan_r, scan_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic [FLAG_PAD-1:0]   full_r, full_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [ANS_W-1:0]      out_ans_r, out_ans_nxt;

  logic [WORD_BITS-1:0]  mem [STORE_WORDS];
  logic [WORD_BITS-1:0]  rdata_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [WORD_BITS-1:0]  mem_wd;

  logic [FLAG_CHUNK-1:0] flag_chunks [CHUNKS];
  logic [WORD_BITS-1:0]  newword;
  logic [WORD_BITS-1:0]  masked;
  logic [SCAN_W-1:0]     next_word;
  logic [CH_W-1:0]       ch;
  logic [OFF_W-1:0]      off;
  logic [FLAG_CHUNK-1:0] cmask;
  logic [SCAN_W-1:0]     wfound;
  logic [SCAN_W-1:0]     next_chunk;
  logic [CAND_W-1:0]     cand;
  logic [CAND_W-1:0]     ans;

  for (genvar c = 0; c < CHUNKS; c++) begin : g_chunk
    assign flag_chunks[c] = full_r[c*FLAG_CHUNK +: FLAG_CHUNK];
  end

  assign newword = rdata_r | (WORD_BITS'(1) << bit_r);
  assign masked = ~rdata_r & ({WORD_BITS{1'b1}} << bit_r);
  assign next_word = SCAN_W'(word_r) + SCAN_W'(1);
  assign ch = CH_W'(scan_r >> OFF_W);
  assign off = scan_r[OFF_W-1:0];
  assign cmask = ~flag_chunks[ch] & ({FLAG_CHUNK{1'b1}} << off);
  assign wfound = SCAN_W'({ch, OFF_W'(ffs(64'(cmask)))});
  assign next_chunk = SCAN_W'({ch, OFF_W'(0)}) + SCAN_W'(FLAG_CHUNK);

  always_comb begin
    cand = none_r ? CAND_W'(STORE_WORDS * WORD_BITS)
                  : CAND_W'(32'(word_r) * WORD_BITS) + CAND_W'(pos_r);
    ans = (cand >= CAND_W'(VALUE_RANGE)) ? CAND_W'(VALUE_RANGE) : cand;
  end

  always_comb begin
    state_nxt = state_r;
    word_nxt = word_r;
    bit_nxt = bit_r;
    pos_nxt = pos_r;
    none_nxt = none_r;
    ins_nxt = ins_r;
    scan_nxt = scan_r;
    clr_nxt = clr_r;
    full_nxt = full_r;
    out_v_nxt = out_v_r && !out_if.ready;
    out_ans_nxt = out_ans_r;
    mem_we = 1'b0;
    mem_wa = word_r;
    mem_wd = newword;
    pop = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(STORE_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          word_nxt = q_entry.word[IDX_W-1:0];
          bit_nxt = q_entry.bit_idx[BIT_W-1:0];
          ins_nxt = (q_entry.kind == KIND_INSERT);
          none_nxt = (q_entry.kind == KIND_NONE);
          state_nxt = (q_entry.kind == KIND_NONE) ? ST_RESULT : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ins_r ? ST_INSERT : ST_EXAM;
      end
      ST_INSERT: begin
        mem_we = 1'b1;
        if (&newword) begin
          full_nxt[FP_W'(word_r)] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_EXAM: begin
        pos_nxt = BIT_W'(ffs(64'(masked)));
        if (|masked) begin
          none_nxt = 1'b0;
          state_nxt = ST_RESULT;
        end else if (32'(next_word) >= STORE_WORDS) begin
          none_nxt = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          scan_nxt = next_word;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (|cmask) begin
          if (32'(wfound) >= STORE_WORDS) begin
            none_nxt = 1'b1;
            state_nxt = ST_RESULT;
          end else begin
            word_nxt = wfound[IDX_W-1:0];
            bit_nxt = '0;
            state_nxt = ST_READ;
          end
        end else if (32'(next_chunk) >= STORE_WORDS) begin
          none_nxt = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          scan_nxt = next_chunk;
        end
      end
      ST_RESULT: begin
        if (!out_v_r || out_if.ready) begin
          out_v_nxt = 1'b1;
          out_ans_nxt = ans[ANS_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      full_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      full_r <= full_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    bit_r <= bit_nxt;
    pos_r <= pos_nxt;
    none_r <= none_nxt;
    ins_r <= ins_nxt;
    scan_r <= scan_nxt;
    out_ans_r <= out_ans_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[word_r];
  end

  assign clearing = (state_r == ST_CLEAR);
  assign out_if.valid = out_v_r;
  assign out_if.answer = out_ans_r;

endmodule

// File: rtl/set_insert_next_absent_query_top.sv
// Channel | Direction | Word
// in_if   | in        | action, value (insert when action is 0, query when 1)
// out_if  | out       | answer (one word per query, none per insert)
//
// Insert: the back end reads the word, sets the bit and writes it back.
// Query: answered from the operand's own bitmap word when it holds a zero at or above it;
// otherwise the full-word flags are scanned 32 at a time and the word found is read and examined.
// Front stage and 2-deep queue let inputs run ahead.
// After reset the bitmap is cleared, one word a cycle (64 words by default);
// in_if.ready stays low meanwhile.
// out_if stalls hold the result register and, once the queue fills, in_if.ready.
module set_insert_next_absent_query_top import sinq_pkg::*; #(
  parameter int VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  sinq_in_if.sink    in_if,
  sinq_out_if.source out_if
);

  logic   q_valid;
  entry_t q_entry;
  logic   pop;
  logic   clearing;

  sinq_front #(
    .VALUE_RANGE (VALUE_RANGE),
    .WORD_BITS   (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .clearing (clearing),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_entry  (q_entry)
  );

  sinq_back #(
    .VALUE_RANGE (VALUE_RANGE),
    .WORD_BITS   (WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .clearing (clearing),
    .out_if   (out_if)
  );

endmodule

// File: rtl/sinq_chk.sv
module sinq_chk import sinq_pkg::*; #(
  parameter int VALUE_RANGE = DEF_VALUE_RANGE
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ANS_W-1:0] out_answer
);

  // bitmap clear follows every reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input accepted straight after reset");

  a_answer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_answer) <= VALUE_RANGE) || (VALUE_RANGE >= (1 << ANS_W)))
    else $error("answer beyond value range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_answer))
    else $error("result word changed while stalled");

endmodule

bind set_insert_next_absent_query_top sinq_chk #(
  .VALUE_RANGE (VALUE_RANGE)
) u_sinq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_answer (out_if.answer)
);

// File: verif/set_insert_next_absent_query_top_tb.sv
`timescale 1ns / 100ps

module set_insert_next_absent_query_top_tb;
  import sinq_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RANGE = DEF_VALUE_RANGE;
  localparam int WBITS = DEF_WORD_BITS;
  localparam int NWORDS = (RANGE + WBITS - 1) / WBITS;
  localparam int TOTAL_WORDS = 1700;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  class next_absent_board;
    bit [WBITS-1:0]   marks [NWORDS];
    logic [ANS_W-1:0] answers_due [$];
    int mismatches;
    int checked;
    int inserts;
    int queries;
    int full_answers;
    int longest_skip;

    function int first_clear(int from);
      for (int k = from; k < RANGE; k++) begin
        if (!marks[k / WBITS][k % WBITS]) return k;
      end
      return RANGE;
    endfunction

    function void note_word(logic act, logic [VAL_W-1:0] v);
      int ans;
      if (act == ACT_INSERT) begin
        inserts++;
        if (int'(v) < RANGE) marks[v / WBITS][v % WBITS] = 1'b1;
      end else begin
        queries++;
        ans = first_clear(int'(v));
        if (ans == RANGE) full_answers++;
        if (ans - int'(v) > longest_skip) longest_skip = ans - int'(v);
        answers_due.push_back(ans[ANS_W-1:0]);
      end
    endfunction

    function void check_answer(logic [ANS_W-1:0] got);
      logic [ANS_W-1:0] want;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("answer %0d arrived with no query outstanding", got);
        return;
      end
      want = answers_due.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("answer mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sinq_in_if  in_bus ();
  sinq_out_if out_bus ();

  set_insert_next_absent_query_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  next_absent_board board;
  int words_sent;
  int src_idle_pct = 12;
  int snk_idle_pct = 72;
  int cycles;
  int hold_left;
  bit hold_req;
  bit hold_taken;
  bit stall_done;

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) board.note_word(in_bus.action, in_bus.value);
    if (rst_n && out_bus.valid && out_bus.ready) board.check_answer(out_bus.answer);
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_word(logic act, logic [VAL_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.value <= v;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic fill_run(int start, int len, bit downward);
    int v;
    if (start + len > RANGE) len = RANGE - start;
    for (int k = 0; k < len; k++) begin
      v = downward ? start + len - 1 - k : start + k;
      send_word(ACT_INSERT, v[VAL_W-1:0]);
      if ($urandom_range(99) < 8) send_word(ACT_QUERY, start[VAL_W-1:0]);
    end
  endtask

  task automatic set_profile();
    int v;
    if (words_sent < TOTAL_WORDS / 3) begin
      src_idle_pct = 12;
      snk_idle_pct = 72;
    end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
      src_idle_pct = 72;
      snk_idle_pct = 12;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
      if (!stall_done) begin
        stall_done = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) begin
          v = $urandom_range(RANGE - 1);
          send_word(ACT_QUERY, v[VAL_W-1:0]);
        end
      end
    end
  endtask

  initial begin
    int frontier;
    int start;
    int len;
    int pick;
    int v;

    board = new();
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_INSERT;
    in_bus.value = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty set, both ends
    send_word(ACT_QUERY, 12'd0);
    send_word(ACT_QUERY, 12'd4095);
    send_word(ACT_QUERY, 12'd2048);
    // insert, then the same value again
    send_word(ACT_INSERT, 12'd0);
    send_word(ACT_QUERY, 12'd0);
    send_word(ACT_INSERT, 12'd0);
    send_word(ACT_QUERY, 12'd0);
    // top of range: nothing absent above 4095 once it is marked
    send_word(ACT_INSERT, 12'd4095);
    send_word(ACT_QUERY, 12'd4095);
    send_word(ACT_QUERY, 12'd4094);
    send_word(ACT_INSERT, 12'd4094);
    send_word(ACT_QUERY, 12'd4094);
    send_word(ACT_QUERY, 12'd4093);
    // across a word boundary
    send_word(ACT_INSERT, 12'd63);
    send_word(ACT_QUERY, 12'd63);
    send_word(ACT_INSERT, 12'd64);
    send_word(ACT_QUERY, 12'd63);
    send_word(ACT_INSERT, 12'd2048);
    send_word(ACT_QUERY, 12'd2047);
    send_word(ACT_QUERY, 12'd2048);

    frontier = 512;
    while (words_sent < TOTAL_WORDS) begin
      set_profile();
      pick = $urandom_range(99);
      if (pick < 12) begin
        len = $urandom_range(8, 100);
        if ($urandom_range(3) == 0) begin
          start = $urandom_range(RANGE - 1);
        end else begin
          start = frontier;
          frontier += len;
          if (frontier >= RANGE) frontier = $urandom_range(1023);
        end
        fill_run(start, len, $urandom_range(1));
      end else if (pick < 72) begin
        if ($urandom_range(1)) v = frontier - $urandom_range(900);
        else v = -1;
        if (v < 0) v = $urandom_range(RANGE - 1);
        send_word(ACT_QUERY, v[VAL_W-1:0]);
      end else begin
        v = $urandom_range(RANGE - 1);
        send_word(ACT_INSERT, v[VAL_W-1:0]);
      end
    end
    in_bus.valid <= 1'b0;

    while (board.answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d queries, three idle profiles, %0d-cycle hold-off.",
             board.inserts, board.queries, LONG_HOLD);
    $display("%0d answers checked, %0d with none absent, longest marked run crossed %0d.",
             board.checked, board.full_answers, board.longest_skip);
    if (board.mismatches == 0 && board.answers_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
